[rtl/kmd_pkg.sv]
package kmd_pkg;

	localparam int FIELD_COLUMNS = 4;
	localparam int ROW_W         = 2;
	localparam int LEVEL_W       = 4;
	localparam int TIME_W        = 32;
	localparam int CFG_W         = 16;
	localparam int COUNT_W       = 32;
	localparam int COL_W         = 2;
	localparam int IN_TDATA_W    = 40;
	localparam int OUT_TDATA_W   = 56;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_COOLDOWN = 1'b1;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd30;
	localparam logic [CFG_W-1:0] COOLDOWN_RESET = 16'd250;

	typedef struct packed {
		logic stable;
		logic press_hit;
		logic release_hit;
	} lane_flags_t;

	typedef struct packed {
		logic [COUNT_W-1:0] press_count;
		logic               seen;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   column;
	} key_status_t;

endpackage

[rtl/key_matrix_debouncer_with_cooldown.sv]
// Channel   Dir  Signals                            Content
// s_*       in   s_tvalid s_tready s_tdata[39:0]    one scanned row sample
// m_*       out  m_tvalid m_tready m_tdata[55:0]    one result per sample
// apb       in   psel penable pwrite paddr pwdata   debounce_time @0, cooldown_time @4
//
// One sample per cycle while s_tready is high; a sample's result is registered and
// offered in the cycle after its transfer. All column lanes compare and write their
// key state in the transfer cycle of an in-range row; merge adds the press total.
// The output register holds a result while m_tready is low; s_tready stays high
// as long as that register is empty or being drained in the same cycle.
// Reset clears all key state, the press total and the registers to defaults.
module key_matrix_debouncer_with_cooldown #(
	parameter int ROW_COUNT    = 4,
	parameter int COLUMN_COUNT = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// row_index[1:0], column_levels[5:2], time_now[37:6], zero[39:38]
	input  logic [kmd_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// row_echo[1:0], stable_levels[5:2], press_mask[9:6], release_mask[13:10],
	// press_count[45:14], last_key_valid[46], last_key_row[48:47],
	// last_key_column[50:49], zero[55:51]
	output logic [kmd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kmd_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [kmd_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [kmd_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int LANES = (COLUMN_COUNT < kmd_pkg::FIELD_COLUMNS) ?
		COLUMN_COUNT : kmd_pkg::FIELD_COLUMNS;
	localparam int ROWS_USED = (ROW_COUNT < 4) ? ROW_COUNT : 4;
	localparam int RW = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;

	logic [kmd_pkg::CFG_W-1:0]    debounce_q;
	logic [kmd_pkg::CFG_W-1:0]    cooldown_q;
	logic                         cfg_wr;

	logic [kmd_pkg::ROW_W-1:0]    row_index;
	logic [kmd_pkg::LEVEL_W-1:0]  column_levels;
	logic [kmd_pkg::TIME_W-1:0]   time_now;
	logic                         s_xfer;
	logic                         row_ok;
	logic                         step_en;

	kmd_pkg::lane_flags_t         lane_flags [LANES];
	logic [LANES-1:0]             stable_v;
	logic [LANES-1:0]             press_v;
	logic [LANES-1:0]             release_v;
	kmd_pkg::key_status_t         status_cur;
	kmd_pkg::key_status_t         status_nxt;

	logic                         out_valid_q;
	logic [kmd_pkg::OUT_TDATA_W-1:0] out_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kmd_pkg::DEBOUNCE_RESET;
			cooldown_q <= kmd_pkg::COOLDOWN_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				kmd_pkg::REG_DEBOUNCE: debounce_q <= pwdata[kmd_pkg::CFG_W-1:0];
				kmd_pkg::REG_COOLDOWN: cooldown_q <= pwdata[kmd_pkg::CFG_W-1:0];
				default:               debounce_q <= debounce_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			kmd_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_q};
			kmd_pkg::REG_COOLDOWN: prdata = {16'd0, cooldown_q};
			default:               prdata = '0;
		endcase
	end

	assign row_index     = s_tdata[1:0];
	assign column_levels = s_tdata[5:2];
	assign time_now      = s_tdata[37:6];

	assign s_tready = ~out_valid_q | m_tready;
	assign s_xfer   = s_tvalid & s_tready;
	assign row_ok   = (32'(row_index) < ROW_COUNT);
	assign step_en  = s_xfer & row_ok;

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		kmd_lane #(
			.ROWS(ROWS_USED)
		) u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.en            (step_en),
			.row_sel       (row_index[RW-1:0]),
			.raw           (column_levels[c]),
			.time_now      (time_now),
			.debounce_time (debounce_q),
			.cooldown_time (cooldown_q),
			.flags         (lane_flags[c])
		);
		assign stable_v[c]  = lane_flags[c].stable;
		assign press_v[c]   = lane_flags[c].press_hit;
		assign release_v[c] = lane_flags[c].release_hit;
	end

	kmd_merge #(
		.LANES(LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (step_en),
		.row        (row_index),
		.press_mask (press_v),
		.status_cur (status_cur),
		.status_nxt (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			out_q <= {5'd0,
				status_nxt.column,
				status_nxt.row,
				status_nxt.seen,
				status_nxt.press_count,
				kmd_pkg::LEVEL_W'(release_v),
				kmd_pkg::LEVEL_W'(press_v),
				kmd_pkg::LEVEL_W'(stable_v),
				row_index};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_mask_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[9:6] & m_tdata[13:10]) == 4'd0))
		else $error("press and release flagged for the same key");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> (m_tdata[45:14] ==
			$past(status_cur.press_count) + 32'($countones(m_tdata[9:6]))))
		else $error("press total does not follow the press mask");

	a_row_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(s_xfer && !row_ok) |=> (m_tdata[13:2] == 12'd0))
		else $error("row outside the matrix reported key activity");

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(status_cur.seen))
		else $error("last key valid dropped");

endmodule

[rtl/kmd_lane.sv]
module kmd_lane #(
	parameter int ROWS = 4,
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [RW-1:0]                 row_sel,
	input  logic                          raw,
	input  logic [kmd_pkg::TIME_W-1:0]    time_now,
	input  logic [kmd_pkg::CFG_W-1:0]     debounce_time,
	input  logic [kmd_pkg::CFG_W-1:0]     cooldown_time,
	output kmd_pkg::lane_flags_t          flags
);

	logic [ROWS-1:0]                stable_q;
	logic [ROWS-1:0]                pending_q;
	logic [kmd_pkg::TIME_W-1:0]     start_q [ROWS];
	logic [kmd_pkg::TIME_W-1:0]     event_q [ROWS];

	logic                           pend;
	logic                           stab;
	logic [kmd_pkg::TIME_W-1:0]     held;
	logic [kmd_pkg::TIME_W-1:0]     since;
	logic                           change;

	always_comb begin
		pend   = pending_q[row_sel];
		stab   = stable_q[row_sel];
		held   = time_now - start_q[row_sel];
		since  = time_now - event_q[row_sel];
		change = (raw == pend) && (pend != stab)
			&& (held >= {16'd0, debounce_time})
			&& (since >= {16'd0, cooldown_time});
		flags.stable      = en & (change ? pend : stab);
		flags.press_hit   = en & change & pend;
		flags.release_hit = en & change & ~pend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q  <= '0;
			pending_q <= '0;
			for (int r = 0; r < ROWS; r++) begin
				start_q[r] <= '0;
				event_q[r] <= '0;
			end
		end else if (en) begin
			if (raw != pend) begin
				pending_q[row_sel] <= raw;
				start_q[row_sel]   <= time_now;
			end else if (change) begin
				stable_q[row_sel] <= pend;
				event_q[row_sel]  <= time_now;
			end
		end
	end

endmodule

[rtl/kmd_merge.sv]
module kmd_merge #(
	parameter int LANES = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [kmd_pkg::ROW_W-1:0]     row,
	input  logic [LANES-1:0]              press_mask,
	output kmd_pkg::key_status_t          status_cur,
	output kmd_pkg::key_status_t          status_nxt
);

	kmd_pkg::key_status_t        status_q;
	logic [2:0]                  inc;
	logic [kmd_pkg::COL_W-1:0]   top_col;

	always_comb begin
		inc     = '0;
		top_col = '0;
		for (int c = 0; c < LANES; c++) begin
			inc = inc + 3'(press_mask[c]);
			if (press_mask[c])
				top_col = kmd_pkg::COL_W'(c);
		end
		status_nxt = status_q;
		if (en && (|press_mask)) begin
			status_nxt.press_count = status_q.press_count + kmd_pkg::COUNT_W'(inc);
			status_nxt.seen        = 1'b1;
			status_nxt.row         = row;
			status_nxt.column      = top_col;
		end
	end

	assign status_cur = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
		end else if (en) begin
			status_q <= status_nxt;
		end
	end

endmodule
